### hdl/i2c_master_register_access_sequencer_core_macros.svh
// assertion helpers for the register access sequencer
`ifndef I2C_MASTER_REGISTER_ACCESS_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define I2CRAS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2c sequencer check failed");

// next-cycle implication
`define I2CRAS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2c sequencer check failed");

`endif

### hdl/i2cras_pkg.sv
`default_nettype none

package i2cras_pkg;

    // transmit store geometry
    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // item kinds
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;
    localparam logic [1:0] REQ_LOAD  = 2'd3;

    // reported mode
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_READY = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // start commands
    localparam logic [1:0] START_NONE  = 2'd0;
    localparam logic [1:0] START_SET   = 2'd1;
    localparam logic [1:0] START_CLEAR = 2'd2;

    // ack commands
    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // bus status codes (status masked with STATUS_MASK)
    localparam logic [7:0] STATUS_MASK   = 8'hF8;
    localparam logic [7:0] ST_BUS_ERR    = 8'h00;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_RXDATA_ACK = 8'h50;
    localparam logic [7:0] ST_RXDATA_NAK = 8'h58;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] slave_addr_w;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] bus_status;
        logic [7:0] bus_data;
        logic [7:0] buf_index;
        logic [7:0] buf_value;
    } t_item;

    typedef struct packed {
        logic       accepted;
        logic       drive_valid;
        logic [7:0] drive_byte;
        logic [1:0] start_cmd;
        logic       stop_cmd;
        logic [1:0] ack_cmd;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_done;
        logic       rx_done;
        logic [1:0] mode;
    } t_result;

endpackage

`default_nettype wire

### hdl/i2cras_ram.sv
`default_nettype none

// simple dual port ram, registered read
module i2cras_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1<<ADDR_W)-1];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/i2cras_ctrl.sv
`default_nettype none

// transfer state and per-item decision
module i2cras_ctrl import i2cras_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire t_item             i_item,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    output t_result                o_res,
    output logic                   o_use_mem,
    output logic                   o_mem_we,
    output logic [BUF_AW-1:0]      o_mem_waddr,
    output logic [7:0]             o_mem_wdata,
    output logic [BUF_AW-1:0]      o_mem_raddr,
    output logic [1:0]             o_busy_mode
);

    logic       r_enable,      n_enable;
    logic [1:0] r_busy_mode,   n_busy_mode;
    logic [7:0] r_target_addr, n_target_addr;
    logic [7:0] r_target_reg,  n_target_reg;
    logic [7:0] r_bytes_left,  n_bytes_left;
    logic [7:0] r_tx_pos,      n_tx_pos;
    logic [7:0] w_code;

    assign w_code = i_item.bus_status & STATUS_MASK;

    // decision for one item
    always_comb begin
        n_enable      = r_enable;
        n_busy_mode   = r_busy_mode;
        n_target_addr = r_target_addr;
        n_target_reg  = r_target_reg;
        n_bytes_left  = r_bytes_left;
        n_tx_pos      = r_tx_pos;
        o_res         = '0;
        o_use_mem     = 1'b0;
        if (i_accept) begin
            unique case (i_item.req_type)
                REQ_WRITE, REQ_READ: begin
                    if (r_enable && r_busy_mode == MODE_READY) begin
                        n_busy_mode     = (i_item.req_type == REQ_WRITE) ? MODE_WRITE : MODE_READ;
                        n_target_addr   = i_item.slave_addr_w;
                        n_target_reg    = i_item.reg_addr;
                        n_bytes_left    = i_item.length;
                        n_tx_pos        = 8'd0;
                        o_res.accepted  = 1'b1;
                        o_res.start_cmd = START_SET;
                    end
                end
                REQ_EVENT: begin
                    if (r_enable) begin
                        unique case (w_code)
                            ST_BUS_ERR: begin
                                o_res.stop_cmd = 1'b1;
                            end
                            ST_START: begin
                                o_res.drive_valid = 1'b1;
                                o_res.drive_byte  = r_target_addr;
                                o_res.start_cmd   = START_CLEAR;
                            end
                            ST_RSTART: begin
                                o_res.drive_valid = 1'b1;
                                o_res.drive_byte  = r_target_addr + 8'd1;
                                o_res.start_cmd   = START_CLEAR;
                            end
                            ST_SLAW_ACK: begin
                                o_res.drive_valid = 1'b1;
                                o_res.drive_byte  = r_target_reg;
                            end
                            ST_DATA_ACK: begin
                                if (r_busy_mode == MODE_READ) begin
                                    o_res.start_cmd = START_SET;
                                end else if (r_busy_mode == MODE_WRITE) begin
                                    if (r_bytes_left == 8'd0) begin
                                        o_res.stop_cmd = 1'b1;
                                        o_res.tx_done  = 1'b1;
                                        n_busy_mode    = MODE_READY;
                                    end else begin
                                        // byte is read from the store and comes back in the next cycle
                                        o_res.drive_valid = 1'b1;
                                        o_use_mem         = 1'b1;
                                        n_tx_pos          = r_tx_pos + 8'd1;
                                        n_bytes_left      = r_bytes_left - 8'd1;
                                    end
                                end
                            end
                            ST_ARB_LOST: begin
                            end
                            ST_SLAR_ACK: begin
                                n_bytes_left  = r_bytes_left - 8'd1;
                                o_res.ack_cmd = (n_bytes_left != 8'd0) ? ACK_ACK : ACK_NACK;
                            end
                            ST_RXDATA_ACK: begin
                                o_res.rx_valid = 1'b1;
                                o_res.rx_byte  = i_item.bus_data;
                                n_bytes_left   = r_bytes_left - 8'd1;
                                o_res.ack_cmd  = (n_bytes_left != 8'd0) ? ACK_ACK : ACK_NACK;
                            end
                            ST_RXDATA_NAK: begin
                                o_res.rx_valid = 1'b1;
                                o_res.rx_byte  = i_item.bus_data;
                                o_res.stop_cmd = 1'b1;
                                o_res.rx_done  = 1'b1;
                                n_busy_mode    = MODE_READY;
                            end
                            default: begin
                                o_res.stop_cmd = 1'b1;
                                n_busy_mode    = MODE_READY;
                            end
                        endcase
                    end
                end
                REQ_LOAD: begin
                end
                default: begin
                end
            endcase
        end
        o_res.mode = r_enable ? n_busy_mode : MODE_OFF;
        // config write
        if (i_cfg_we) begin
            n_enable = i_cfg_data;
            if (i_cfg_data) begin
                n_busy_mode = MODE_READY;
            end
        end
    end

    // store access
    assign o_mem_we    = i_accept && (i_item.req_type == REQ_LOAD);
    assign o_mem_waddr = i_item.buf_index[BUF_AW-1:0];
    assign o_mem_wdata = i_item.buf_value;
    assign o_mem_raddr = r_tx_pos[BUF_AW-1:0];
    assign o_busy_mode = r_busy_mode;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_busy_mode   <= MODE_READY;
            r_target_addr <= 8'd0;
            r_target_reg  <= 8'd0;
            r_bytes_left  <= 8'd0;
            r_tx_pos      <= 8'd0;
        end else begin
            r_enable      <= n_enable;
            r_busy_mode   <= n_busy_mode;
            r_target_addr <= n_target_addr;
            r_target_reg  <= n_target_reg;
            r_bytes_left  <= n_bytes_left;
            r_tx_pos      <= n_tx_pos;
        end
    end

endmodule

`default_nettype wire

### hdl/i2cras_out.sv
`default_nettype none

// two result stages: store read stage and output register
module i2cras_out import i2cras_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_result    i_res,
    input  wire logic       i_use_mem,
    input  wire logic [7:0] i_mem_q,
    input  wire logic       i_m_ready,
    output logic            o_s_ready,
    output logic            o_m_valid,
    output t_result         o_res
);

    logic    r_s1_v;
    t_result r_s1_res;
    logic    r_s1_use;
    logic    r_s2_v;
    t_result r_s2_res;
    logic    w_s1_move;
    t_result w_s1_fin;

    assign w_s1_move = !r_s2_v || i_m_ready;
    assign o_s_ready = !r_s1_v || w_s1_move;

    // drive byte from the store where the decision asked for it
    always_comb begin
        w_s1_fin = r_s1_res;
        if (r_s1_use) begin
            w_s1_fin.drive_byte = i_mem_q;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (o_s_ready) begin
                r_s1_v <= i_accept;
            end
            if (w_s1_move) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_res <= i_res;
            r_s1_use <= i_use_mem;
        end
        if (w_s1_move && r_s1_v) begin
            r_s2_res <= w_s1_fin;
        end
    end

    assign o_m_valid = r_s2_v;
    assign o_res     = r_s2_res;

endmodule

`default_nettype wire

### hdl/i2c_master_register_access_sequencer_core.sv
// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   i_s_tuser req_type, i_s_tdata request fields
// m         out  o_m_tvalid / i_m_tready   o_m_tdata result fields
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data enable
//
// one item per cycle unless m stalls; each result is registered in both result stages
// the transmit byte of a write is read from the store ram in the cycle after the decision
// synchronous active-low reset clears transfer state; the store ram has no reset
// a stall on m backs up through two result stages to o_s_tready
`default_nettype none

module i2c_master_register_access_sequencer_core import i2cras_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [7:0] slave_addr_w, [15:8] reg_addr, [23:16] length, [31:24] bus_status,
    // [39:32] bus_data, [47:40] buf_index, [55:48] buf_value
    input  wire logic [55:0] i_s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] accepted, [1] drive_valid, [9:2] drive_byte, [11:10] start_cmd, [12] stop_cmd,
    // [14:13] ack_cmd, [15] rx_valid, [23:16] rx_byte, [24] tx_done, [25] rx_done,
    // [27:26] mode, [31:28] zero
    output logic [31:0]      o_m_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

`include "i2c_master_register_access_sequencer_core_macros.svh"

    logic              w_in_beat;
    t_item             w_item;
    t_result           w_res;
    t_result           w_out_res;
    logic              w_use_mem;
    logic              w_mem_we;
    logic [BUF_AW-1:0] w_mem_waddr;
    logic [7:0]        w_mem_wdata;
    logic [BUF_AW-1:0] w_mem_raddr;
    logic [7:0]        w_mem_q;
    logic [1:0]        w_busy_mode;
    logic              w_cfg_we;

    assign w_in_beat   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // unpack input beat
    assign w_item.req_type     = i_s_tuser;
    assign w_item.slave_addr_w = i_s_tdata[7:0];
    assign w_item.reg_addr     = i_s_tdata[15:8];
    assign w_item.length       = i_s_tdata[23:16];
    assign w_item.bus_status   = i_s_tdata[31:24];
    assign w_item.bus_data     = i_s_tdata[39:32];
    assign w_item.buf_index    = i_s_tdata[47:40];
    assign w_item.buf_value    = i_s_tdata[55:48];

    i2cras_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_beat),
        .i_item      (w_item),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_res       (w_res),
        .o_use_mem   (w_use_mem),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .o_busy_mode (w_busy_mode)
    );

    i2cras_ram #(
        .ADDR_W (BUF_AW),
        .DATA_W (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_in_beat && w_use_mem),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_q)
    );

    i2cras_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_in_beat),
        .i_res     (w_res),
        .i_use_mem (w_use_mem),
        .i_mem_q   (w_mem_q),
        .i_m_ready (i_m_tready),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .o_res     (w_out_res)
    );

    // pack output beat
    assign o_m_tdata = {4'd0,
                        w_out_res.mode,
                        w_out_res.rx_done,
                        w_out_res.tx_done,
                        w_out_res.rx_byte,
                        w_out_res.rx_valid,
                        w_out_res.ack_cmd,
                        w_out_res.stop_cmd,
                        w_out_res.start_cmd,
                        w_out_res.drive_byte,
                        w_out_res.drive_valid,
                        w_out_res.accepted};

    // checks
    `I2CRAS_ASSERT_IMP(a_tx_done_stops, o_m_tvalid && w_out_res.tx_done,
        w_out_res.stop_cmd && w_out_res.mode == MODE_READY)
    `I2CRAS_ASSERT_IMP(a_rx_done_stops, o_m_tvalid && w_out_res.rx_done,
        w_out_res.stop_cmd && w_out_res.rx_valid && w_out_res.mode == MODE_READY)
    `I2CRAS_ASSERT_IMP(a_accept_starts, o_m_tvalid && w_out_res.accepted,
        w_out_res.start_cmd == START_SET &&
        (w_out_res.mode == MODE_WRITE || w_out_res.mode == MODE_READ))
    `I2CRAS_ASSERT_NXT(a_accept_busy, w_in_beat && w_res.accepted && !w_cfg_we,
        w_busy_mode == MODE_WRITE || w_busy_mode == MODE_READ)

endmodule

`default_nettype wire

### verif/i2c_master_register_access_sequencer_core_test.sv
`timescale 1ns / 100ps

module i2c_master_register_access_sequencer_core_test;
    import i2cras_pkg::*;

    // status codes that end a transfer without a name in the package
    localparam logic [7:0] ST_SLAW_NAK    = 8'h20;
    localparam logic [7:0] ST_DATA_NAK    = 8'h30;
    localparam logic [7:0] ST_SLAR_NAK    = 8'h48;
    localparam logic [7:0] ST_UNKNOWN_LO  = 8'h60;
    localparam logic [7:0] ST_UNKNOWN_TOP = 8'hF8;

    // two copies of the sequencer state: one walks ahead while stimulus is built,
    // the other follows the beats the block actually takes
    localparam int GEN = 0;
    localparam int CHK = 1;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 60;

    typedef struct packed {
        logic       enable;
        logic [1:0] busy;
        logic [7:0] addr;
        logic [7:0] regno;
        logic [7:0] left;
        logic [7:0] pos;
    } t_seq_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    t_seq_state  seq_view [2];
    logic [7:0]  tx_copy [2][BUF_DEPTH];
    bit          loaded [BUF_DEPTH];

    t_item       ops_todo [$];
    t_result     replies_due [$];
    t_item       on_bus;

    int          n_sent = 0;
    int          n_bad = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          hold_left = 0;
    bit          held_once = 1'b0;
    bit          calm = 1'b0;
    int          quiet = 0;

    i2c_master_register_access_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // decision for one item, advancing copy k of the sequencer state
    function automatic t_result sequencer_step(input int k, input t_item it);
        t_result    r;
        logic [7:0] code;
        r = '0;
        case (it.req_type)
            REQ_WRITE, REQ_READ: begin
                if (seq_view[k].enable && seq_view[k].busy == MODE_READY) begin
                    seq_view[k].busy  = (it.req_type == REQ_WRITE) ? MODE_WRITE : MODE_READ;
                    seq_view[k].addr  = it.slave_addr_w;
                    seq_view[k].regno = it.reg_addr;
                    seq_view[k].left  = it.length;
                    seq_view[k].pos   = 8'd0;
                    r.accepted  = 1'b1;
                    r.start_cmd = START_SET;
                end
            end
            REQ_EVENT: begin
                if (seq_view[k].enable) begin
                    code = it.bus_status & STATUS_MASK;
                    case (code)
                        ST_BUS_ERR: r.stop_cmd = 1'b1;
                        ST_START: begin
                            r.drive_valid = 1'b1;
                            r.drive_byte  = seq_view[k].addr;
                            r.start_cmd   = START_CLEAR;
                        end
                        ST_RSTART: begin
                            // SLA+R wraps within the byte
                            r.drive_valid = 1'b1;
                            r.drive_byte  = seq_view[k].addr + 8'd1;
                            r.start_cmd   = START_CLEAR;
                        end
                        ST_SLAW_ACK: begin
                            r.drive_valid = 1'b1;
                            r.drive_byte  = seq_view[k].regno;
                        end
                        ST_DATA_ACK: begin
                            if (seq_view[k].busy == MODE_READ) begin
                                r.start_cmd = START_SET;
                            end else if (seq_view[k].busy == MODE_WRITE) begin
                                if (seq_view[k].left == 8'd0) begin
                                    r.stop_cmd = 1'b1;
                                    r.tx_done  = 1'b1;
                                    seq_view[k].busy = MODE_READY;
                                end else begin
                                    r.drive_valid = 1'b1;
                                    r.drive_byte  = tx_copy[k][seq_view[k].pos];
                                    seq_view[k].pos  = seq_view[k].pos + 8'd1;
                                    seq_view[k].left = seq_view[k].left - 8'd1;
                                end
                            end
                        end
                        ST_ARB_LOST: ;
                        ST_SLAR_ACK, ST_RXDATA_ACK: begin
                            if (code == ST_RXDATA_ACK) begin
                                r.rx_valid = 1'b1;
                                r.rx_byte  = it.bus_data;
                            end
                            // zero length wraps to 255 here
                            seq_view[k].left = seq_view[k].left - 8'd1;
                            r.ack_cmd = (seq_view[k].left != 8'd0) ? ACK_ACK : ACK_NACK;
                        end
                        ST_RXDATA_NAK: begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = it.bus_data;
                            r.stop_cmd = 1'b1;
                            r.rx_done  = 1'b1;
                            seq_view[k].busy = MODE_READY;
                        end
                        default: begin
                            r.stop_cmd = 1'b1;
                            seq_view[k].busy = MODE_READY;
                        end
                    endcase
                end
            end
            default: tx_copy[k][it.buf_index] = it.buf_value;
        endcase
        r.mode = seq_view[k].enable ? seq_view[k].busy : MODE_OFF;
        return r;
    endfunction

    // item builders, every field random unless set
    function automatic t_item any_item();
        t_item it;
        it.req_type     = 2'($urandom_range(0, 3));
        it.slave_addr_w = 8'($urandom);
        it.reg_addr     = 8'($urandom);
        it.length       = 8'($urandom);
        it.bus_status   = 8'($urandom);
        it.bus_data     = 8'($urandom);
        it.buf_index    = 8'($urandom);
        it.buf_value    = 8'($urandom);
        return it;
    endfunction

    function automatic t_item ev(input logic [7:0] code);
        t_item it;
        it = any_item();
        it.req_type   = REQ_EVENT;
        it.bus_status = code | 8'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic t_item ask(input logic [1:0] kind, input logic [7:0] sla,
                                  input logic [7:0] regno, input logic [7:0] len);
        t_item it;
        it = any_item();
        it.req_type     = kind;
        it.slave_addr_w = sla;
        it.reg_addr     = regno;
        it.length       = len;
        return it;
    endfunction

    function automatic t_item load(input logic [7:0] idx, input logic [7:0] val);
        t_item it;
        it = any_item();
        it.req_type  = REQ_LOAD;
        it.buf_index = idx;
        it.buf_value = val;
        return it;
    endfunction

    function automatic logic [7:0] abort_code();
        case ($urandom_range(0, 3))
            0: return ST_SLAW_NAK;
            1: return ST_DATA_NAK;
            2: return ST_SLAR_NAK;
            default: return 8'(ST_UNKNOWN_LO + 8 * $urandom_range(0, 19));
        endcase
    endfunction

    function automatic int pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 12) return 0;
        if (p < 80) return $urandom_range(1, 6);
        if (p < 99) return $urandom_range(7, 24);
        return $urandom_range(200, 255);
    endfunction

    // queue one item; a data byte never comes from a store entry that was not loaded
    task automatic push_op(input t_item it);
        t_item fill;
        if (it.req_type == REQ_EVENT && seq_view[GEN].enable
                && seq_view[GEN].busy == MODE_WRITE
                && (it.bus_status & STATUS_MASK) == ST_DATA_ACK
                && seq_view[GEN].left != 8'd0 && !loaded[seq_view[GEN].pos]) begin
            fill = load(seq_view[GEN].pos, 8'($urandom));
            loaded[fill.buf_index] = 1'b1;
            void'(sequencer_step(GEN, fill));
            ops_todo.push_back(fill);
        end
        if (it.req_type == REQ_LOAD) loaded[it.buf_index] = 1'b1;
        void'(sequencer_step(GEN, it));
        ops_todo.push_back(it);
    endtask

    // one register transfer, well formed or cut short
    task automatic run_txn(input logic [1:0] kind, input int len, input bit broken);
        t_item steps [$];
        int    cut;
        int    n_rx;
        if (seq_view[GEN].enable && seq_view[GEN].busy != MODE_READY) push_op(ev(abort_code()));
        if (kind == REQ_WRITE) begin
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) != 0) push_op(load(8'(i), 8'($urandom)));
            end
        end
        steps.push_back(ask(kind, 8'($urandom), 8'($urandom), 8'(len)));
        steps.push_back(ev(ST_START));
        steps.push_back(ev(ST_SLAW_ACK));
        if (kind == REQ_WRITE) begin
            for (int i = 0; i <= len; i++) steps.push_back(ev(ST_DATA_ACK));
        end else begin
            steps.push_back(ev(ST_DATA_ACK));
            steps.push_back(ev(ST_RSTART));
            steps.push_back(ev(ST_SLAR_ACK));
            n_rx = (len == 0) ? $urandom_range(0, 4) : len - 1;
            repeat (n_rx) steps.push_back(ev(ST_RXDATA_ACK));
            steps.push_back(ev(ST_RXDATA_NAK));
        end
        if (broken) begin
            cut = $urandom_range(1, steps.size() - 1);
            while (steps.size() > cut) void'(steps.pop_back());
            case ($urandom_range(0, 3))
                0: steps.push_back(ev(ST_BUS_ERR));
                1: steps.push_back(ev(ST_ARB_LOST));
                default: steps.push_back(ev(abort_code()));
            endcase
        end
        foreach (steps[i]) begin
            if ($urandom_range(0, 15) == 0) push_op(load(8'($urandom), 8'($urandom)));
            push_op(steps[i]);
        end
    endtask

    // fill the queue with transfers and noise until it holds at least n items
    task automatic fill_random(input int n);
        int p;
        while (ops_todo.size() < n) begin
            p = $urandom_range(0, 99);
            if (p < 42) run_txn(REQ_WRITE, pick_len(), 1'b0);
            else if (p < 84) run_txn(REQ_READ, pick_len(), 1'b0);
            else if (p < 92) run_txn($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, pick_len(), 1'b1);
            else repeat ($urandom_range(1, 5)) push_op(any_item());
        end
    endtask

    // let every queued item go through and every result come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (ops_todo.size() != 0 || replies_due.size() != 0 || i_s_tvalid);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_enable(input logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        for (int k = GEN; k <= CHK; k++) begin
            seq_view[k].enable = v;
            if (v) seq_view[k].busy = MODE_READY;
        end
    endtask

    task automatic cmp(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_bad++;
        end
    endtask

    // request side: offer queued items, predict each beat taken
    always @(posedge i_clk) begin : feed
        bit offer;
        offer = 1'b0;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                replies_due.push_back(sequencer_step(CHK, on_bus));
                n_sent++;
            end
            if (src_gap != 0) begin
                src_gap--;
            end else if (ops_todo.size() != 0) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 2);
                end else begin
                    offer  = 1'b1;
                    on_bus = ops_todo.pop_front();
                end
            end
            i_s_tvalid <= offer;
            i_s_tuser  <= on_bus.req_type;
            i_s_tdata  <= {on_bus.buf_value, on_bus.buf_index, on_bus.bus_data,
                           on_bus.bus_status, on_bus.length, on_bus.reg_addr,
                           on_bus.slave_addr_w};
        end
    end

    // result side: compare each beat with the oldest prediction
    always @(posedge i_clk) begin : collect
        t_result want;
        bit      take;
        take = 1'b0;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result beat 0x%08h with no request pending", o_m_tdata);
                    n_bad++;
                end else begin
                    want = replies_due.pop_front();
                    cmp("accepted", 8'(want.accepted), 8'(o_m_tdata[0]));
                    cmp("drive_valid", 8'(want.drive_valid), 8'(o_m_tdata[1]));
                    cmp("drive_byte", want.drive_byte, o_m_tdata[9:2]);
                    cmp("start_cmd", 8'(want.start_cmd), 8'(o_m_tdata[11:10]));
                    cmp("stop_cmd", 8'(want.stop_cmd), 8'(o_m_tdata[12]));
                    cmp("ack_cmd", 8'(want.ack_cmd), 8'(o_m_tdata[14:13]));
                    cmp("rx_valid", 8'(want.rx_valid), 8'(o_m_tdata[15]));
                    cmp("rx_byte", want.rx_byte, o_m_tdata[23:16]);
                    cmp("tx_done", 8'(want.tx_done), 8'(o_m_tdata[24]));
                    cmp("rx_done", 8'(want.rx_done), 8'(o_m_tdata[25]));
                    cmp("mode", 8'(want.mode), 8'(o_m_tdata[27:26]));
                    cmp("pad", 8'h00, 8'(o_m_tdata[31:28]));
                end
            end
            // one long hold-off early on so the block backs up into its input
            if (hold_left != 0) begin
                hold_left--;
            end else if (!held_once && n_sent >= 150) begin
                held_once = 1'b1;
                hold_left = LONG_HOLD - 1;
            end else if (sink_gap != 0) begin
                sink_gap--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 2);
            end else begin
                take = 1'b1;
            end
            i_m_tready <= take;
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : script
        for (int k = GEN; k <= CHK; k++) begin
            seq_view[k] = '0;
            seq_view[k].busy = MODE_READY;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: requests refused, events ignored, loads still land
        push_op(ask(REQ_WRITE, 8'h50, 8'h10, 8'd3));
        push_op(ev(ST_START));
        push_op(load(8'd0, 8'hFF));
        push_op(load(8'hFF, 8'h00));
        push_op(load(8'd1, 8'h5A));
        wait_drained();
        set_enable(1'b1);

        // data ack while ready does nothing
        push_op(ev(ST_DATA_ACK));
        // write to the top address, then a request refused while busy
        push_op(ask(REQ_WRITE, 8'hFF, 8'h00, 8'd2));
        push_op(ask(REQ_READ, 8'h00, 8'hFF, 8'hFF));
        push_op(ev(ST_START));
        push_op(ev(ST_SLAW_ACK));
        push_op(ev(ST_DATA_ACK));
        // store rewritten in the middle of a transfer
        push_op(load(8'd1, 8'hA5));
        push_op(ev(ST_DATA_ACK));
        // receive event ends the write
        push_op(ev(ST_RXDATA_NAK));
        // empty write completes at once
        push_op(ask(REQ_WRITE, 8'h00, 8'h7E, 8'd0));
        push_op(ev(ST_START));
        push_op(ev(ST_SLAW_ACK));
        push_op(ev(ST_DATA_ACK));
        // empty read: SLA+R wraps, count wraps, arbitration loss and bus error keep going
        push_op(ask(REQ_READ, 8'hFF, 8'h33, 8'd0));
        push_op(ev(ST_START));
        push_op(ev(ST_SLAW_ACK));
        push_op(ev(ST_DATA_ACK));
        push_op(ev(ST_RSTART));
        push_op(ev(ST_SLAR_ACK));
        push_op(ev(ST_RXDATA_ACK));
        push_op(ev(ST_ARB_LOST));
        push_op(ev(ST_BUS_ERR));
        push_op(ev(ST_RXDATA_NAK));
        // unknown status while ready
        push_op(ev(ST_UNKNOWN_TOP));
        wait_drained();

        // enabled, random transfers with the long hold-off
        fill_random(380);
        wait_drained();

        // disabled again
        set_enable(1'b0);
        fill_random(60);
        wait_drained();

        // enabled again; the mode returns to ready whatever state the transfer was left in
        set_enable(1'b1);
        fill_random(280);
        wait_drained();

        // enable rewritten while already set, then a stretch with no idling
        set_enable(1'b1);
        calm = 1'b1;
        fill_random(100);
        wait_drained();

        if (n_bad == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
